// File: rtl/complex_arithmetic_unit_core_defines.svh
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_core_defines
// Assertion macros used by the complex arithmetic unit core.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_CORE_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define CAU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cau: implication check failed");
`define CAU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cau: next-cycle check failed");
`else
`define CAU_ASSERT_IMP(lbl, ante, cons)
`define CAU_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: rtl/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Types, widths and helpers for the complex arithmetic unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package cau_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int PW        = 2 * WORD_BITS + 2;  // product sums, signed
  localparam int RW        = 3 * WORD_BITS + 2;  // divider remainder
  localparam int QB        = WORD_BITS + 1;      // quotient bits = cells

  localparam logic [2:0] ACT_CONJ = 3'd0;
  localparam logic [2:0] ACT_ADD  = 3'd1;
  localparam logic [2:0] ACT_SUB  = 3'd2;
  localparam logic [2:0] ACT_MUL  = 3'd3;
  localparam logic [2:0] ACT_DIV  = 3'd4;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DZ  = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef struct packed {
    logic [2:0]                  action;
    logic signed [WORD_BITS-1:0] a_re;
    logic signed [WORD_BITS-1:0] a_im;
    logic signed [WORD_BITS-1:0] b_re;
    logic signed [WORD_BITS-1:0] b_im;
  } in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] res_re;
    logic signed [WORD_BITS-1:0] res_im;
    logic [1:0]                  status;
  } out_t;

  typedef struct packed {
    in_t                           op;
    logic signed [2*WORD_BITS-1:0] p_rr;  // a_re*b_re
    logic signed [2*WORD_BITS-1:0] p_ii;  // a_im*b_im
    logic signed [2*WORD_BITS-1:0] p_ir;  // a_im*b_re
    logic signed [2*WORD_BITS-1:0] p_ri;  // a_re*b_im
    logic signed [2*WORD_BITS-1:0] p_bb;  // b_re*b_re
    logic signed [2*WORD_BITS-1:0] p_cc;  // b_im*b_im
  } prod_t;

  typedef struct packed {
    logic [2:0]                  action;
    logic                        dz;
    logic signed [WORD_BITS:0]   lin_re;
    logic signed [WORD_BITS:0]   lin_im;
    logic signed [2*WORD_BITS:0] mr;
    logic signed [2*WORD_BITS:0] mi;
    logic signed [2*WORD_BITS:0] nr;
    logic signed [2*WORD_BITS:0] ni;
    logic [2*WORD_BITS-1:0]      den;
  } sum_t;

  typedef struct packed {
    logic                   div;
    logic                   dz;
    logic [WORD_BITS-1:0]   pre_re;
    logic [WORD_BITS-1:0]   pre_im;
    logic                   pre_sat;
    logic                   neg_re;
    logic                   neg_im;
    logic                   ovf_re;
    logic                   ovf_im;
    logic [2*WORD_BITS-1:0] den;
    logic [RW-1:0]          rem_re;
    logic [RW-1:0]          rem_im;
    logic [QB-1:0]          q_re;
    logic [QB-1:0]          q_im;
  } cell_t;

  // {saturated, value}
  function automatic logic [WORD_BITS:0] sat_word(input logic signed [PW-1:0] v);
    logic [PW-WORD_BITS:0] hi;
    hi = v[PW-1:WORD_BITS-1];
    if (hi == '0 || hi == '1) begin
      return {1'b0, v[WORD_BITS-1:0]};
    end else if (v[PW-1]) begin
      return {1'b1, WORD_MIN};
    end else begin
      return {1'b1, WORD_MAX};
    end
  endfunction

  // quotient magnitude plus sign to saturated word: {saturated, value}
  function automatic logic [WORD_BITS:0] div_word(input logic [QB-1:0] q,
                                                  input logic neg, input logic ovf);
    logic big;
    if (neg) begin
      big = ovf | q[WORD_BITS] | (q[WORD_BITS-1] & (|q[WORD_BITS-2:0]));
      return big ? {1'b1, WORD_MIN} : {1'b0, -q[WORD_BITS-1:0]};
    end else begin
      big = ovf | q[WORD_BITS] | q[WORD_BITS-1];
      return big ? {1'b1, WORD_MAX} : {1'b0, q[WORD_BITS-1:0]};
    end
  endfunction

endpackage

// File: rtl/complex_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_core
// Pipelined complex ALU in signed Q16.16: conjugate, add, sub, mul, div.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one operation (action plus both operands).
//   out_valid/out_stall/out_data return one result per operation, in order.
//   A transfer happens on a rising edge with valid high and stall low.
// Path: from input transfer to out_valid an operation passes multiply, sum,
//   prepare, 33 quotient-bit cells and the output register; every operation takes
//   the same path, so results never reorder.
// Throughput: one operation per cycle while out_stall is low; each division
//   cell resolves one quotient bit for both parts, and the cell row sets the latency.
// Stall: every stage holds its item only while the next one is full and
//   stalled, so bubbles collapse and input keeps flowing until the pipe is full.
// Reset: synchronous, active low; clears all stage valids, the pipe is
//   empty and ready the cycle after reset is released.
// Status: 0 ok, 1 divide by zero (results zero), 2 a result part saturated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "complex_arithmetic_unit_core_defines.svh"
module complex_arithmetic_unit_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  cau_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output cau_pkg::out_t out_data
);
  import cau_pkg::*;

  logic  a_vld, a_rdy, b_vld, b_rdy;
  prod_t a_data;
  sum_t  b_data;

  logic  cv [QB+1];
  logic  cr [QB+2];
  cell_t cd [QB+1];

  logic  o_vld_r;
  out_t  o_data_r;
  out_t  o_data_nxt;
  logic  o_rdy;
  logic [WORD_BITS:0] d_re, d_im;

  cau_mult u_mult (
    .clk(clk), .rst_n(rst_n),
    .vld_i(in_valid), .rdy_o(a_rdy), .data_i(in_data),
    .vld_o(a_vld), .rdy_i(b_rdy), .data_o(a_data)
  );

  cau_sum u_sum (
    .clk(clk), .rst_n(rst_n),
    .vld_i(a_vld), .rdy_o(b_rdy), .data_i(a_data),
    .vld_o(b_vld), .rdy_i(cr[0]), .data_o(b_data)
  );

  cau_prep u_prep (
    .clk(clk), .rst_n(rst_n),
    .vld_i(b_vld), .rdy_o(cr[0]), .data_i(b_data),
    .vld_o(cv[0]), .rdy_i(cr[1]), .data_o(cd[0])
  );

  // cell k resolves quotient bit QB-1-k, msb first
  for (genvar k = 0; k < QB; k++) begin : g_cell
    cau_div_cell #(.BIT(QB - 1 - k)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .vld_i(cv[k]), .rdy_o(cr[k+1]), .data_i(cd[k]),
      .vld_o(cv[k+1]), .rdy_i(cr[k+2]), .data_o(cd[k+1])
    );
  end

  assign in_stall  = !a_rdy;
  assign o_rdy     = !o_vld_r || !out_stall;
  assign cr[QB+1]  = o_rdy;
  assign out_valid = o_vld_r;
  assign out_data  = o_data_r;

  always_comb begin
    d_re = div_word(cd[QB].q_re, cd[QB].neg_re, cd[QB].ovf_re);
    d_im = div_word(cd[QB].q_im, cd[QB].neg_im, cd[QB].ovf_im);
    if (cd[QB].dz) begin
      o_data_nxt.res_re = '0;
      o_data_nxt.res_im = '0;
      o_data_nxt.status = ST_DZ;
    end else if (cd[QB].div) begin
      o_data_nxt.res_re = d_re[WORD_BITS-1:0];
      o_data_nxt.res_im = d_im[WORD_BITS-1:0];
      o_data_nxt.status = (d_re[WORD_BITS] | d_im[WORD_BITS]) ? ST_SAT : ST_OK;
    end else begin
      o_data_nxt.res_re = cd[QB].pre_re;
      o_data_nxt.res_im = cd[QB].pre_im;
      o_data_nxt.status = cd[QB].pre_sat ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (o_rdy) begin
      o_vld_r <= cv[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (cv[QB] && o_rdy) begin
      o_data_r <= o_data_nxt;
    end
  end

  `CAU_ASSERT_IMP(a_dz_zero, out_valid && out_data.status == ST_DZ, out_data.res_re == '0 && out_data.res_im == '0)
  `CAU_ASSERT_IMP(a_status_code, out_valid, out_data.status == ST_OK || out_data.status == ST_DZ || out_data.status == ST_SAT)
  `CAU_ASSERT_IMP(a_sat_limit, out_valid && out_data.status == ST_SAT, out_data.res_re == WORD_MAX || out_data.res_re == WORD_MIN || out_data.res_im == WORD_MAX || out_data.res_im == WORD_MIN)
  `CAU_ASSERT_NXT(a_cell_hold, cv[QB] && !o_rdy, cv[QB] && $stable(cd[QB].q_re))

endmodule

// File: rtl/cau_mult.sv
// ----------------------------------------------------------------------------
// cau_mult
// First stage: registers the operands and the six partial products.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module cau_mult (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          vld_i,
  output logic          rdy_o,
  input  cau_pkg::in_t  data_i,
  output logic          vld_o,
  input  logic          rdy_i,
  output cau_pkg::prod_t data_o
);
  import cau_pkg::*;

  logic  vld_r;
  prod_t data_r;
  prod_t data_nxt;

  assign rdy_o = !vld_r || rdy_i;
  assign vld_o = vld_r;
  assign data_o = data_r;

  always_comb begin
    data_nxt.op   = data_i;
    data_nxt.p_rr = data_i.a_re * data_i.b_re;
    data_nxt.p_ii = data_i.a_im * data_i.b_im;
    data_nxt.p_ir = data_i.a_im * data_i.b_re;
    data_nxt.p_ri = data_i.a_re * data_i.b_im;
    data_nxt.p_bb = data_i.b_re * data_i.b_re;
    data_nxt.p_cc = data_i.b_im * data_i.b_im;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_i && rdy_o) begin
      data_r <= data_nxt;
    end
  end

endmodule

// File: rtl/cau_sum.sv
// ----------------------------------------------------------------------------
// cau_sum
// Second stage: product sums, divisor energy and the linear ops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module cau_sum (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           vld_i,
  output logic           rdy_o,
  input  cau_pkg::prod_t data_i,
  output logic           vld_o,
  input  logic           rdy_i,
  output cau_pkg::sum_t  data_o
);
  import cau_pkg::*;

  logic vld_r;
  sum_t data_r;
  sum_t data_nxt;

  logic signed [2*WORD_BITS:0] e_rr, e_ii, e_ir, e_ri;
  logic signed [WORD_BITS:0]   ar, ai, br, bi;

  assign rdy_o = !vld_r || rdy_i;
  assign vld_o = vld_r;
  assign data_o = data_r;

  always_comb begin
    e_rr = (2*WORD_BITS+1)'(data_i.p_rr);
    e_ii = (2*WORD_BITS+1)'(data_i.p_ii);
    e_ir = (2*WORD_BITS+1)'(data_i.p_ir);
    e_ri = (2*WORD_BITS+1)'(data_i.p_ri);
    ar   = (WORD_BITS+1)'(data_i.op.a_re);
    ai   = (WORD_BITS+1)'(data_i.op.a_im);
    br   = (WORD_BITS+1)'(data_i.op.b_re);
    bi   = (WORD_BITS+1)'(data_i.op.b_im);

    data_nxt.action = data_i.op.action;
    data_nxt.dz     = (data_i.op.b_re == '0) && (data_i.op.b_im == '0);
    data_nxt.mr     = e_rr - e_ii;
    data_nxt.mi     = e_ir + e_ri;
    data_nxt.nr     = e_rr + e_ii;
    data_nxt.ni     = e_ir - e_ri;
    data_nxt.den    = $unsigned(data_i.p_bb) + $unsigned(data_i.p_cc);

    unique case (data_i.op.action)
      ACT_CONJ: begin
        data_nxt.lin_re = ar;
        data_nxt.lin_im = -ai;
      end
      ACT_ADD: begin
        data_nxt.lin_re = ar + br;
        data_nxt.lin_im = ai + bi;
      end
      ACT_SUB: begin
        data_nxt.lin_re = ar - br;
        data_nxt.lin_im = ai - bi;
      end
      default: begin
        data_nxt.lin_re = '0;
        data_nxt.lin_im = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_i && rdy_o) begin
      data_r <= data_nxt;
    end
  end

endmodule

// File: rtl/cau_prep.sv
// ----------------------------------------------------------------------------
// cau_prep
// Third stage: rounds and saturates the non-divide results and loads the
// divider dividends (magnitude scaled by 2^F plus half the divisor).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module cau_prep (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           vld_i,
  output logic           rdy_o,
  input  cau_pkg::sum_t  data_i,
  output logic           vld_o,
  input  logic           rdy_i,
  output cau_pkg::cell_t data_o
);
  import cau_pkg::*;

  localparam logic signed [PW-1:0] RND = PW'(1) << (FRAC_BITS - 1);

  logic  vld_r;
  cell_t data_r;
  cell_t data_nxt;

  logic signed [PW-1:0]  t_re, t_im;
  logic [WORD_BITS:0]    s_re, s_im;
  logic [2*WORD_BITS:0]  m_re, m_im;
  logic [RW-1:0]         half, lim;

  assign rdy_o = !vld_r || rdy_i;
  assign vld_o = vld_r;
  assign data_o = data_r;

  always_comb begin
    if (data_i.action == ACT_MUL) begin
      t_re = PW'(data_i.mr);
      t_im = PW'(data_i.mi);
      t_re = (t_re + RND) >>> FRAC_BITS;
      t_im = (t_im + RND) >>> FRAC_BITS;
    end else begin
      t_re = PW'(data_i.lin_re);
      t_im = PW'(data_i.lin_im);
    end
    s_re = sat_word(t_re);
    s_im = sat_word(t_im);

    m_re = data_i.nr[2*WORD_BITS] ? $unsigned(-data_i.nr) : $unsigned(data_i.nr);
    m_im = data_i.ni[2*WORD_BITS] ? $unsigned(-data_i.ni) : $unsigned(data_i.ni);
    half = RW'(data_i.den >> 1);
    lim  = RW'(data_i.den) << (WORD_BITS + 1);

    data_nxt.div     = (data_i.action == ACT_DIV) && !data_i.dz;
    data_nxt.dz      = (data_i.action == ACT_DIV) && data_i.dz;
    data_nxt.pre_re  = s_re[WORD_BITS-1:0];
    data_nxt.pre_im  = s_im[WORD_BITS-1:0];
    data_nxt.pre_sat = s_re[WORD_BITS] | s_im[WORD_BITS];
    data_nxt.neg_re  = data_i.nr[2*WORD_BITS];
    data_nxt.neg_im  = data_i.ni[2*WORD_BITS];
    data_nxt.den     = data_i.den;
    data_nxt.rem_re  = (RW'(m_re) << FRAC_BITS) + half;
    data_nxt.rem_im  = (RW'(m_im) << FRAC_BITS) + half;
    data_nxt.ovf_re  = data_nxt.rem_re >= lim;
    data_nxt.ovf_im  = data_nxt.rem_im >= lim;
    data_nxt.q_re    = '0;
    data_nxt.q_im    = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_i && rdy_o) begin
      data_r <= data_nxt;
    end
  end

endmodule

// File: rtl/cau_div_cell.sv
// ----------------------------------------------------------------------------
// cau_div_cell
// One restoring-division cell: settles quotient bit BIT of both parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module cau_div_cell #(
  parameter int BIT = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           vld_i,
  output logic           rdy_o,
  input  cau_pkg::cell_t data_i,
  output logic           vld_o,
  input  logic           rdy_i,
  output cau_pkg::cell_t data_o
);
  import cau_pkg::*;

  logic          vld_r;
  cell_t         data_r;
  cell_t         data_nxt;
  logic [RW-1:0] dsh;

  assign rdy_o = !vld_r || rdy_i;
  assign vld_o = vld_r;
  assign data_o = data_r;

  always_comb begin
    dsh      = RW'(data_i.den) << BIT;
    data_nxt = data_i;
    if (data_i.rem_re >= dsh) begin
      data_nxt.rem_re   = data_i.rem_re - dsh;
      data_nxt.q_re[BIT] = 1'b1;
    end
    if (data_i.rem_im >= dsh) begin
      data_nxt.rem_im   = data_i.rem_im - dsh;
      data_nxt.q_im[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_i && rdy_o) begin
      data_r <= data_nxt;
    end
  end

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the complex ALU (conjugate, add, sub, mul, div in Q16.16) against a
// behavioral predictor: a directed table, then random operations, with random
// gaps on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  import cau_pkg::*;

  localparam int W = WORD_BITS;
  localparam int F = FRAC_BITS;
  localparam int N_RAND = 1200;

  typedef struct {
    in_t  op;
    logic known;   // expected result typed into the table
    out_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  out_t expected_q[$];
  int   mismatches = 0;
  int   stall_left = 0;
  bit   feeding_done = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  complex_arithmetic_unit_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // saturate a wide signed value to a word; flags overflow
  function automatic logic signed [W-1:0] clamp(input logic signed [127:0] v,
                                                inout logic sat);
    logic signed [127:0] hi_lim, lo_lim;
    hi_lim = (128'sd1 <<< (W - 1)) - 1;
    lo_lim = -(128'sd1 <<< (W - 1));
    if (v > hi_lim) begin
      sat = 1'b1;
      return WORD_MAX;
    end else if (v < lo_lim) begin
      sat = 1'b1;
      return WORD_MIN;
    end
    return v[W-1:0];
  endfunction

  // round-to-nearest, ties away from zero
  function automatic logic signed [127:0] quot_part(input logic signed [127:0] num,
                                                    input logic signed [127:0] den);
    logic [127:0] m, q;
    m = num < 0 ? -num : num;
    q = ((m << F) + (den >>> 1)) / den;
    return num < 0 ? -$signed(q) : $signed(q);
  endfunction

  function automatic out_t complex_result(input in_t op);
    logic signed [127:0] ar, ai, br, bi, rnd, den;
    logic sat;
    out_t r;
    ar = 128'(op.a_re); ai = 128'(op.a_im); br = 128'(op.b_re); bi = 128'(op.b_im);
    rnd = 128'sd1 <<< (F - 1);
    sat = 1'b0;
    r = '0;
    r.status = ST_OK;
    case (op.action)
      ACT_CONJ: begin
        r.res_re = op.a_re;
        r.res_im = clamp(-ai, sat);
      end
      ACT_ADD: begin
        r.res_re = clamp(ar + br, sat);
        r.res_im = clamp(ai + bi, sat);
      end
      ACT_SUB: begin
        r.res_re = clamp(ar - br, sat);
        r.res_im = clamp(ai - bi, sat);
      end
      ACT_MUL: begin
        r.res_re = clamp((ar * br - ai * bi + rnd) >>> F, sat);
        r.res_im = clamp((ai * br + ar * bi + rnd) >>> F, sat);
      end
      ACT_DIV: begin
        if (br == 0 && bi == 0) begin
          r.status = ST_DZ;
        end else begin
          den = br * br + bi * bi;
          r.res_re = clamp(quot_part(ar * br + ai * bi, den), sat);
          r.res_im = clamp(quot_part(ai * br - ar * bi, den), sat);
        end
      end
      default: ;
    endcase
    if (r.status == ST_OK && sat) r.status = ST_SAT;
    return r;
  endfunction

  function automatic logic [W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return '0;
      3: return W'($signed($urandom_range(0, 8)) - 4) << F;   // small integers
      4: return W'($signed($urandom_range(0, 2000)) - 1000) << ($urandom_range(0, F));
      5: return {{(W-16){$urandom_range(0, 1) == 1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic in_t rand_op();
    in_t op;
    op.action = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
    op.a_re = rand_word();
    op.a_im = rand_word();
    op.b_re = rand_word();
    op.b_im = rand_word();
    if (op.action == ACT_DIV && $urandom_range(0, 15) == 0) begin
      op.b_re = '0;
      op.b_im = '0;
    end
    return op;
  endfunction

  function automatic row_t mk(input logic [2:0] act, input logic [W-1:0] ar,
                              input logic [W-1:0] ai, input logic [W-1:0] br,
                              input logic [W-1:0] bi);
    row_t r;
    r.op = '{act, ar, ai, br, bi};
    r.known = 1'b0;
    r.res = '0;
    return r;
  endfunction

  function automatic row_t mkx(input logic [2:0] act, input logic [W-1:0] ar,
                               input logic [W-1:0] ai, input logic [W-1:0] br,
                               input logic [W-1:0] bi, input out_t res);
    row_t r;
    r = mk(act, ar, ai, br, bi);
    r.known = 1'b1;
    r.res = res;
    return r;
  endfunction

  // valid stays high across back-to-back transfers, drops only for a gap
  task automatic send(input in_t op, input out_t exp_res);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    expected_q.push_back(exp_res);
    in_data  <= op;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  localparam logic [W-1:0] ONE = 1 << F;
  localparam logic [W-1:0] ZW  = '0;

  initial begin
    row_t dir[$];
    in_t  op;
    out_t res;
    dir.push_back(mkx(ACT_CONJ, ONE, WORD_MIN, ZW, ZW, '{ONE, WORD_MAX, ST_SAT}));
    dir.push_back(mkx(ACT_CONJ, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN,
                      '{WORD_MIN, WORD_MIN + 1, ST_OK}));
    dir.push_back(mkx(ACT_ADD, WORD_MAX, WORD_MIN, ONE, WORD_MAX,
                      '{WORD_MAX, 32'hFFFFFFFF, ST_SAT}));
    dir.push_back(mkx(ACT_ADD, WORD_MIN, ZW, WORD_MIN, ZW, '{WORD_MIN, ZW, ST_SAT}));
    dir.push_back(mkx(ACT_SUB, WORD_MIN, WORD_MAX, ONE, WORD_MIN,
                      '{WORD_MIN, WORD_MAX, ST_SAT}));
    dir.push_back(mkx(ACT_SUB, ONE, ONE, ONE, ONE, '{ZW, ZW, ST_OK}));
    dir.push_back(mkx(ACT_MUL, ONE, ZW, ONE, ZW, '{ONE, ZW, ST_OK}));
    dir.push_back(mk(ACT_MUL, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
    dir.push_back(mk(ACT_MUL, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
    dir.push_back(mk(ACT_MUL, 32'h00008000, 32'h00000001, 32'h00000001, 32'hFFFF8000));
    dir.push_back(mk(ACT_MUL, 32'hFFFFFFFF, 32'h00000001, 32'h00008000, 32'h00008000));
    dir.push_back(mkx(ACT_DIV, WORD_MAX, WORD_MIN, ZW, ZW, '{ZW, ZW, ST_DZ}));
    dir.push_back(mkx(ACT_DIV, ONE, ONE, ONE, ZW, '{ONE, ONE, ST_OK}));
    dir.push_back(mk(ACT_DIV, WORD_MAX, WORD_MIN, 32'h00000001, ZW));
    dir.push_back(mk(ACT_DIV, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
    dir.push_back(mk(ACT_DIV, 32'h00000001, ZW, 32'h00000003, 32'h00000003));
    dir.push_back(mk(ACT_DIV, WORD_MAX, WORD_MAX, WORD_MIN, 32'h00000001));
    dir.push_back(mk(ACT_DIV, 32'hFFFFFFFF, ZW, ZW, 32'h00000002));
    dir.push_back(mkx(3'd5, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, '{ZW, ZW, ST_OK}));
    dir.push_back(mkx(3'd6, ONE, ONE, ONE, ONE, '{ZW, ZW, ST_OK}));
    dir.push_back(mkx(3'd7, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, '{ZW, ZW, ST_OK}));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir[i]) begin
      res = dir[i].known ? dir[i].res : complex_result(dir[i].op);
      send(dir[i].op, res);
    end
    repeat (N_RAND) begin
      op = rand_op();
      send(op, complex_result(op));
    end
    in_valid <= 1'b0;
    feeding_done = 1'b1;
  end

  function automatic void res_check(input out_t e);
    if (out_data.res_re !== e.res_re || out_data.res_im !== e.res_im ||
        out_data.status !== e.status) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected re=%h im=%h st=%0d, got re=%h im=%h st=%0d",
                 e.res_re, e.res_im, e.status,
                 out_data.res_re, out_data.res_im, out_data.status);
    end
  endfunction

  // result side: after each transfer, stall for a random number of cycles
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data);
        end else begin
          res_check(expected_q.pop_front());
        end
        stall_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    wait (feeding_done);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end
endmodule
